[src/i2c_eeprom_slave_with_write_lock_top_macros.svh]
// Assertion macros shared by the checker of the EEPROM slave.
// Depends on nothing; the user supplies clk_i and rst_ni in scope.
`ifndef I2C_EEPROM_SLAVE_WITH_WRITE_LOCK_TOP_MACROS_SVH
`define I2C_EEPROM_SLAVE_WITH_WRITE_LOCK_TOP_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define I2CEE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define I2CEE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/i2cee_pkg.sv]
// Shared types and constants of the I2C EEPROM slave with write lock.
// Used by the front end, queue, back end and top level.
package i2cee_pkg;

  localparam int unsigned STORE_BYTES_DEF = 1024;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned ADDR_VAL_W      = 16;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_CODE  = 2'd3;

  localparam logic [7:0] CHAR_L = 8'h4C;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_O = 8'h4F;
  localparam logic [7:0] CHAR_K = 8'h4B;

  typedef enum logic [2:0] {
    OP_ARM      = 3'd0,
    OP_HIGH     = 3'd1,
    OP_SETPTR   = 3'd2,
    OP_WRITE    = 3'd3,
    OP_READ     = 3'd4,
    OP_READ_SET = 3'd5,
    OP_CODE     = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    PH_NONE = 3'b001,
    PH_HIGH = 3'b010,
    PH_LOW  = 3'b100
  } phase_e;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_L    = 2'd1,
    PEND_C    = 2'd2
  } pend_e;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_MOD   = 5'b00100,
    S_RDA   = 5'b01000,
    S_RD    = 5'b10000
  } bstate_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic [7:0] high;
  } item_t;

  typedef struct packed {
    logic       done;
    logic [7:0] read_data;
    logic       locked;
    logic       stored;
  } result_t;

endpackage

[src/i2c_eeprom_slave_with_write_lock_top.sv]
// Top level of the I2C EEPROM slave with write lock.
// Instantiates i2cee_front, i2cee_fifo and i2cee_back; depends on i2cee_pkg.

// After reset the block erases its store to 0xFF, one byte per cycle, and holds
// busy high until the whole store is erased. A beat is taken when start is high
// and busy is low; it enters a two-entry queue, and the back end picks it up
// once idle. Every beat yields one registered result, shown for a single cycle
// with done_o high. Start, lock code bytes, the high address byte and data
// writes finish straight from idle; a read passes through S_RD, because the store
// read is registered. Loading the pointer from a full address goes through a
// modulo unit built on a reciprocal multiplication, and a read right after a
// single address byte then passes through S_RDA and S_RD. The receiver cannot
// stall; busy rises only while the store is erased or the queue is full.
module i2c_eeprom_slave_with_write_lock_top #(
  parameter int unsigned STORE_BYTES = i2cee_pkg::STORE_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] cmd_i,
  input  logic [7:0] data_i,
  output logic       done_o,
  output logic [7:0] read_data_o,
  output logic       locked_o,
  output logic       stored_o
);

  i2cee_pkg::item_t   push_item, pop_item;
  i2cee_pkg::result_t result;
  logic               push, pop, q_valid, q_full, clearing;

  i2cee_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .data_i     (data_i),
    .full_i     (q_full),
    .clearing_i (clearing),
    .push_o     (push),
    .item_o     (push_item)
  );

  i2cee_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (pop_item),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  i2cee_back #(
    .STORE_BYTES (STORE_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (pop_item),
    .q_pop_o    (pop),
    .clearing_o (clearing),
    .result_o   (result)
  );

  assign done_o      = result.done;
  assign read_data_o = result.read_data;
  assign locked_o    = result.locked;
  assign stored_o    = result.stored;

endmodule

[src/i2cee_front.sv]
// Front end: accepts bus events and classifies them into store operations.
// Tracks the address capture phase; depends on i2cee_pkg.
module i2cee_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd_i,
  input  logic [7:0]         data_i,
  input  logic               full_i,
  input  logic               clearing_i,
  output logic               push_o,
  output i2cee_pkg::item_t   item_o
);

  i2cee_pkg::phase_e phase_q, phase_d;
  logic [7:0]        high_q, high_d;

  assign busy   = full_i | clearing_i;
  assign push_o = start & ~busy;

  always_comb begin
    phase_d     = phase_q;
    high_d      = high_q;
    item_o.data = data_i;
    item_o.high = high_q;
    item_o.op   = i2cee_pkg::OP_CODE;
    unique case (cmd_i)
      i2cee_pkg::CMD_START: begin
        item_o.op = i2cee_pkg::OP_ARM;
        phase_d   = i2cee_pkg::PH_HIGH;
      end
      i2cee_pkg::CMD_WRITE: begin
        priority if (phase_q == i2cee_pkg::PH_HIGH) begin
          item_o.op = i2cee_pkg::OP_HIGH;
          high_d    = data_i;
          phase_d   = i2cee_pkg::PH_LOW;
        end else if (phase_q == i2cee_pkg::PH_LOW) begin
          item_o.op = i2cee_pkg::OP_SETPTR;
          phase_d   = i2cee_pkg::PH_NONE;
        end else begin
          item_o.op = i2cee_pkg::OP_WRITE;
        end
      end
      i2cee_pkg::CMD_READ: begin
        // A read after only the high address byte loads the pointer from it.
        if (phase_q == i2cee_pkg::PH_LOW) begin
          item_o.op = i2cee_pkg::OP_READ_SET;
          phase_d   = i2cee_pkg::PH_NONE;
        end else begin
          item_o.op = i2cee_pkg::OP_READ;
        end
      end
      i2cee_pkg::CMD_CODE: begin
        item_o.op = i2cee_pkg::OP_CODE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= i2cee_pkg::PH_NONE;
      high_q  <= 8'h00;
    end else if (push_o) begin
      phase_q <= phase_d;
      high_q  <= high_d;
    end
  end

endmodule

[src/i2cee_fifo.sv]
// Short queue between the front end and the back end.
// Holds classified items; depends on i2cee_pkg.
module i2cee_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  i2cee_pkg::item_t item_i,
  input  logic             pop_i,
  output i2cee_pkg::item_t item_o,
  output logic             valid_o,
  output logic             full_o
);

  localparam int unsigned IW = (i2cee_pkg::QUEUE_DEPTH > 1) ?
                               $clog2(i2cee_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(i2cee_pkg::QUEUE_DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(i2cee_pkg::QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(i2cee_pkg::QUEUE_DEPTH);

  i2cee_pkg::item_t entry_q [i2cee_pkg::QUEUE_DEPTH];
  logic [IW-1:0]    wp_q, rp_q;
  logic [CW-1:0]    cnt_q;

  assign item_o  = entry_q[rp_q];
  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == DEPTH_C);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wp_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == LAST_IDX) ? '0 : wp_q + IW'(1);
      end
      if (pop_i) begin
        rp_q <= (rp_q == LAST_IDX) ? '0 : rp_q + IW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

[src/i2cee_back.sv]
// Back end: byte store, address pointer, modulo unit and write lock.
// Executes queued items and registers one result each; depends on i2cee_pkg.
module i2cee_back #(
  parameter int unsigned STORE_BYTES = i2cee_pkg::STORE_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  i2cee_pkg::item_t   q_item_i,
  output logic               q_pop_o,
  output logic               clearing_o,
  output i2cee_pkg::result_t result_o
);

  localparam int unsigned AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int unsigned VW = i2cee_pkg::ADDR_VAL_W;
  localparam int unsigned CW = VW + 1;
  localparam int unsigned PW = VW + 32;
  localparam int unsigned BW = VW + CW;
  localparam int unsigned KW = 2;
  localparam logic [AW-1:0] LAST  = AW'(STORE_BYTES - 1);
  localparam logic [CW-1:0] DIVC  = CW'(STORE_BYTES);
  localparam logic [31:0]   RECIP = 32'((64'd1 << 32) / 64'(STORE_BYTES));
  localparam logic [KW-1:0] MOD_QUO = KW'(2);
  localparam logic [KW-1:0] MOD_REM = KW'(1);

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] rdata_q;

  i2cee_pkg::bstate_e state_q, state_d;
  i2cee_pkg::pend_e   pend_q, pend_d;
  logic [AW-1:0]      ptr_q, ptr_d, clr_q, clr_d, ptr_inc, waddr;
  logic [VW-1:0]      rem_q, rem_d, rem_fix;
  logic [VW-1:0]      quo_q, quo_d;
  logic [KW-1:0]      k_q, k_d;
  logic               rd_after_q, rd_after_d;
  logic               locked_q, locked_d;
  i2cee_pkg::result_t res_q, res_d;
  logic               we;
  logic [7:0]         wdata;
  logic [PW-1:0]      prod_rcp;
  logic [BW-1:0]      prod_div;

  // The pointer modulo runs in three steps: a quotient estimate by reciprocal
  // multiplication that is at most one short, the remainder it leaves, and one
  // correcting subtract.
  assign prod_rcp = {{32{1'b0}}, rem_q} * {{VW{1'b0}}, RECIP};
  assign prod_div = {{CW{1'b0}}, quo_q} * {{VW{1'b0}}, DIVC};
  assign rem_fix  = (CW'(rem_q) >= DIVC) ? rem_q - DIVC[VW-1:0] : rem_q;
  assign ptr_inc  = (ptr_q == LAST) ? '0 : ptr_q + AW'(1);

  always_comb begin
    state_d    = state_q;
    pend_d     = pend_q;
    ptr_d      = ptr_q;
    clr_d      = clr_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    k_d        = k_q;
    rd_after_d = rd_after_q;
    locked_d   = locked_q;
    res_d      = '0;
    q_pop_o    = 1'b0;
    we         = 1'b0;
    waddr      = ptr_q;
    wdata      = q_item_i.data;
    unique case (state_q)
      i2cee_pkg::S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = 8'hFF;
        clr_d = clr_q + AW'(1);
        if (clr_q == LAST) begin
          state_d = i2cee_pkg::S_IDLE;
        end
      end
      i2cee_pkg::S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          unique case (q_item_i.op)
            i2cee_pkg::OP_ARM, i2cee_pkg::OP_HIGH: begin
              res_d.done = 1'b1;
            end
            i2cee_pkg::OP_WRITE: begin
              res_d.done = 1'b1;
              if (!locked_q) begin
                we           = 1'b1;
                res_d.stored = 1'b1;
              end
              ptr_d = ptr_inc;
            end
            i2cee_pkg::OP_READ: begin
              state_d = i2cee_pkg::S_RD;
            end
            i2cee_pkg::OP_SETPTR: begin
              rem_d      = {q_item_i.high, q_item_i.data};
              k_d        = MOD_QUO;
              rd_after_d = 1'b0;
              state_d    = i2cee_pkg::S_MOD;
            end
            i2cee_pkg::OP_READ_SET: begin
              rem_d      = VW'(q_item_i.high);
              k_d        = MOD_QUO;
              rd_after_d = 1'b1;
              state_d    = i2cee_pkg::S_MOD;
            end
            i2cee_pkg::OP_CODE: begin
              res_d.done = 1'b1;
              priority if (q_item_i.data == i2cee_pkg::CHAR_L) begin
                pend_d = i2cee_pkg::PEND_L;
              end else if (q_item_i.data == i2cee_pkg::CHAR_C) begin
                pend_d = i2cee_pkg::PEND_C;
              end else begin
                priority if (q_item_i.data == i2cee_pkg::CHAR_O &&
                             pend_q == i2cee_pkg::PEND_L) begin
                  locked_d = 1'b1;
                end else if (q_item_i.data == i2cee_pkg::CHAR_K &&
                             pend_q == i2cee_pkg::PEND_C) begin
                  locked_d = 1'b0;
                end else begin
                  locked_d = locked_q;
                end
                pend_d = i2cee_pkg::PEND_NONE;
              end
            end
            default: begin
              res_d.done = 1'b1;
            end
          endcase
        end
      end
      i2cee_pkg::S_MOD: begin
        unique case (k_q)
          MOD_QUO: begin
            quo_d = prod_rcp[PW-1:32];
            k_d   = MOD_REM;
          end
          MOD_REM: begin
            rem_d = rem_q - prod_div[VW-1:0];
            k_d   = k_q - KW'(1);
          end
          default: begin
            ptr_d = rem_fix[AW-1:0];
            if (rd_after_q) begin
              state_d = i2cee_pkg::S_RDA;
            end else begin
              res_d.done = 1'b1;
              state_d    = i2cee_pkg::S_IDLE;
            end
          end
        endcase
      end
      i2cee_pkg::S_RDA: begin
        // The store read of the freshly loaded pointer lands this cycle.
        state_d = i2cee_pkg::S_RD;
      end
      i2cee_pkg::S_RD: begin
        res_d.done      = 1'b1;
        res_d.read_data = rdata_q;
        ptr_d           = ptr_inc;
        state_d         = i2cee_pkg::S_IDLE;
      end
      default: begin
        state_d = i2cee_pkg::S_IDLE;
      end
    endcase
    res_d.locked = locked_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[ptr_q];
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    k_q        <= k_d;
    rd_after_q <= rd_after_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= i2cee_pkg::S_CLEAR;
      pend_q   <= i2cee_pkg::PEND_NONE;
      ptr_q    <= '0;
      clr_q    <= '0;
      locked_q <= 1'b1;
      res_q    <= '{done: 1'b0, read_data: 8'h00, locked: 1'b1, stored: 1'b0};
    end else begin
      state_q  <= state_d;
      pend_q   <= pend_d;
      ptr_q    <= ptr_d;
      clr_q    <= clr_d;
      locked_q <= locked_d;
      res_q    <= res_d;
    end
  end

  assign clearing_o = (state_q == i2cee_pkg::S_CLEAR);
  assign result_o   = res_q;

endmodule

[src/i2cee_checker.sv]
// Port-level checker for the I2C EEPROM slave with write lock, bound to the top.
// Depends on i2c_eeprom_slave_with_write_lock_top_macros.svh.
`include "i2c_eeprom_slave_with_write_lock_top_macros.svh"

module i2cee_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       done_o,
  input logic [7:0] read_data_o,
  input logic       locked_o,
  input logic       stored_o
);

  // A stored byte implies the store was unlocked and stays so for that beat.
  `I2CEE_ASSERT_IMPL(a_store_unlocked, done_o && stored_o, !locked_o)
  // Outside a result beat the data outputs rest at zero.
  `I2CEE_ASSERT_IMPL(a_idle_quiet, !done_o, read_data_o == 8'h00 && !stored_o)
  // A write beat returns no read data.
  `I2CEE_ASSERT_IMPL(a_store_no_read, done_o && stored_o, read_data_o == 8'h00)
  // The lock status moves only together with a result beat.
  `I2CEE_ASSERT_NEXT(a_lock_with_done, !done_o, !(locked_o != $past(locked_o)) || done_o)

endmodule

bind i2c_eeprom_slave_with_write_lock_top i2cee_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .done_o      (done_o),
  .read_data_o (read_data_o),
  .locked_o    (locked_o),
  .stored_o    (stored_o)
);
